[hdl/multi_reader_ring_descriptor_pool_assert.svh]
// Assertion macros for the ring descriptor pool.
`ifndef MULTI_READER_RING_DESCRIPTOR_POOL_ASSERT_SVH
`define MULTI_READER_RING_DESCRIPTOR_POOL_ASSERT_SVH

`ifndef ASSERT_OFF
`define MRRDP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define MRRDP_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define MRRDP_ASSERT(lbl, prop)
`define MRRDP_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

[hdl/mrrdp_pkg.sv]
// Shared types and constants of the ring descriptor pool.
`timescale 1ns / 1ps
package mrrdp_pkg;

  localparam int unsigned MIN_BYTES      = 1000 * 1024;
  localparam int unsigned RESET_BYTES    = 2000 * 1024;
  localparam int unsigned RESET_CHANNELS = 2;
  localparam int unsigned MIN_FRAME      = 4;

  localparam int unsigned LEN_W      = 23;
  localparam int unsigned STAMP_W    = 32;
  localparam int unsigned KIND_W     = 8;
  localparam int unsigned TAG_W      = 2 * KIND_W;
  localparam int unsigned CHN_W      = 3;
  localparam int unsigned OFFSET_W   = 22;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 23;

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_REJECT      = 2'd1,
    ST_BAD_CHANNEL = 2'd2,
    ST_EMPTY       = 2'd3
  } status_e;

endpackage

[hdl/mrrdp_entry_store.sv]
// Descriptor entry memory: one write port, one registered read port.
`timescale 1ns / 1ps
module mrrdp_entry_store #(
  parameter int unsigned DEPTH = 40,
  parameter int unsigned DW    = 96
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DW-1:0]            wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DW-1:0]            rd_data_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

[hdl/multi_reader_ring_descriptor_pool.sv]
// Top level of the multi-reader ring descriptor pool.
//
// Item channel: an item (push or pop) is taken when start_i is high and busy_o is
// low. The result appears on status_o and the payload ports for exactly one
// cycle with done_o high; busy_o drops in that same cycle, so the next item may
// be taken at the edge that ends it. The receiver cannot stall and must sample then.
// A pop passes S_POP_CHK and, if the reader is valid and its queue non-empty,
// S_POP_OUT. A push passes S_PLACE; unless rejected there, it walks each active
// channel through S_HEAD and S_EVICT in turn while its queue is non-empty,
// evicting each head descriptor that overlaps the new frame, then S_APPEND. This order
// follows the single entry memory read port, walked one queue head at a time.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// ready only while idle and no item is offered. Any write to a known register
// empties all queues and resets the write position; unknown indexes are ignored.
// Reset: queues empty, write position 0, ring size and channel count at
// their defaults. Entry memory is not cleared; empty queues never read it.
`timescale 1ns / 1ps
module multi_reader_ring_descriptor_pool #(
  parameter int unsigned MAX_BUFFER_BYTES = 4194304,
  parameter int unsigned MAX_CHANNELS     = 5,
  parameter int unsigned QUEUE_DEPTH      = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                opcode_i,
  input  logic [mrrdp_pkg::LEN_W-1:0]         frame_length_i,
  input  logic [mrrdp_pkg::STAMP_W-1:0]       stamp_i,
  input  logic [mrrdp_pkg::KIND_W-1:0]        data_kind_i,
  input  logic [mrrdp_pkg::KIND_W-1:0]        nal_kind_i,
  input  logic [mrrdp_pkg::CHN_W-1:0]         reader_i,
  output logic                                done_o,
  output mrrdp_pkg::status_e                  status_o,
  output logic [mrrdp_pkg::OFFSET_W-1:0]      offset_o,
  output logic [mrrdp_pkg::LEN_W-1:0]         out_length_o,
  output logic [mrrdp_pkg::STAMP_W-1:0]       out_stamp_o,
  output logic [mrrdp_pkg::KIND_W-1:0]        out_data_kind_o,
  output logic [mrrdp_pkg::KIND_W-1:0]        out_nal_kind_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mrrdp_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mrrdp_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import mrrdp_pkg::*;

`include "multi_reader_ring_descriptor_pool_assert.svh"

  localparam int unsigned PW    = $clog2(MAX_BUFFER_BYTES + 1);
  localparam int unsigned EW    = PW + 1;
  localparam int unsigned MW    = ((PW > LEN_W) ? PW : LEN_W) + 1;
  localparam int unsigned SLOTS = MAX_CHANNELS * QUEUE_DEPTH;
  localparam int unsigned AW    = $clog2(SLOTS);
  localparam int unsigned HW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned DW    = PW + LEN_W + STAMP_W + TAG_W;
  localparam int unsigned RST_SIZE =
    (RESET_BYTES > MAX_BUFFER_BYTES) ? MAX_BUFFER_BYTES : RESET_BYTES;
  localparam int unsigned RST_CHN =
    (RESET_CHANNELS > MAX_CHANNELS) ? MAX_CHANNELS : RESET_CHANNELS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PLACE,
    S_HEAD,
    S_EVICT,
    S_APPEND,
    S_POP_CHK,
    S_POP_OUT
  } state_e;

  state_e                state_q;
  logic [PW-1:0]         size_q;
  logic [CHN_W-1:0]      chn_q;
  logic [PW-1:0]         wp_q;
  logic [HW-1:0]         head_q  [MAX_CHANNELS];
  logic [CW-1:0]         count_q [MAX_CHANNELS];
  logic [LEN_W-1:0]      len_q;
  logic [STAMP_W-1:0]    stamp_q;
  logic [TAG_W-1:0]      tags_q;
  logic [CHN_W-1:0]      reader_q;
  logic [PW-1:0]         start_q;
  logic [EW-1:0]         end_q;
  logic [CHW-1:0]        ch_q;

  logic                  done_q;
  status_e               status_q;
  logic [OFFSET_W-1:0]   offset_q;
  logic [LEN_W-1:0]      out_length_q;
  logic [STAMP_W-1:0]    out_stamp_q;
  logic [KIND_W-1:0]     out_data_kind_q;
  logic [KIND_W-1:0]     out_nal_kind_q;

  logic [CHW-1:0]        cur_ch;
  logic [AW-1:0]         rd_addr;
  logic [AW-1:0]         wr_addr;
  logic                  wr_en;
  logic [DW-1:0]         wr_data;
  logic [DW-1:0]         rd_data;
  logic [PW-1:0]         rd_start;
  logic [LEN_W-1:0]      rd_len;
  logic [STAMP_W-1:0]    rd_stamp;
  logic [TAG_W-1:0]      rd_tags;
  logic [EW-1:0]         rd_end;
  logic                  overlap;
  logic [MW-1:0]         place_sum;
  logic                  reject;
  logic [HW:0]           tail_sum;
  logic [HW-1:0]         tail_pos;
  logic                  cur_full;
  logic                  last_ch;
  logic                  cfg_wr;
  logic [31:0]           cfg_wide;

  function automatic logic [AW-1:0] slot_addr(input logic [CHW-1:0] ch,
                                              input logic [HW-1:0] pos);
    slot_addr = AW'(int'(ch) * QUEUE_DEPTH + int'(pos));
  endfunction

  function automatic logic [HW-1:0] head_inc(input logic [HW-1:0] h);
    head_inc = (h == HW'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
  endfunction

  assign cur_ch  = (state_q == S_POP_CHK) ? reader_q[CHW-1:0] : ch_q;
  assign rd_addr = slot_addr(cur_ch, head_q[cur_ch]);

  assign cur_full = (count_q[ch_q] == CW'(QUEUE_DEPTH));
  assign tail_sum = (HW + 1)'(head_q[ch_q]) + (HW + 1)'(count_q[ch_q]);
  always_comb begin
    if (cur_full) begin
      tail_pos = head_q[ch_q];
    end else if (tail_sum >= (HW + 1)'(QUEUE_DEPTH)) begin
      tail_pos = HW'(tail_sum - (HW + 1)'(QUEUE_DEPTH));
    end else begin
      tail_pos = HW'(tail_sum);
    end
  end

  assign wr_en   = (state_q == S_APPEND);
  assign wr_addr = slot_addr(ch_q, tail_pos);
  assign wr_data = {start_q, len_q, stamp_q, tags_q};

  mrrdp_entry_store #(
    .DEPTH (SLOTS),
    .DW    (DW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign {rd_start, rd_len, rd_stamp, rd_tags} = rd_data;
  assign rd_end  = EW'(rd_start) + EW'(rd_len);
  assign overlap = !((EW'(rd_start) >= end_q) || (rd_end <= EW'(start_q)));

  assign place_sum = MW'(len_q) + MW'(wp_q);
  assign reject    = (chn_q == '0) || (MW'(len_q) > MW'(size_q)) ||
                     (len_q < LEN_W'(MIN_FRAME));

  assign last_ch  = ((CHN_W + 1)'(ch_q) + 1'b1) == (CHN_W + 1)'(chn_q);
  assign cfg_wr   = cfg_valid_i && cfg_ready_o;
  assign cfg_wide = 32'(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      size_q          <= PW'(RST_SIZE);
      chn_q           <= CHN_W'(RST_CHN);
      wp_q            <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        head_q[i]  <= '0;
        count_q[i] <= '0;
      end
      len_q           <= '0;
      stamp_q         <= '0;
      tags_q          <= '0;
      reader_q        <= '0;
      start_q         <= '0;
      end_q           <= '0;
      ch_q            <= '0;
      done_q          <= 1'b0;
      status_q        <= ST_OK;
      offset_q        <= '0;
      out_length_q    <= '0;
      out_stamp_q     <= '0;
      out_data_kind_q <= '0;
      out_nal_kind_q  <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cfg_wr && (cfg_index_i == CFG_BUFFER_SIZE ||
                         cfg_index_i == CFG_CHANNEL_COUNT)) begin
            if (cfg_index_i == CFG_BUFFER_SIZE) begin
              if (cfg_wide < MIN_BYTES) begin
                size_q <= PW'(MIN_BYTES);
              end else if (cfg_wide > MAX_BUFFER_BYTES) begin
                size_q <= PW'(MAX_BUFFER_BYTES);
              end else begin
                size_q <= PW'(cfg_wide);
              end
            end else begin
              if (32'(cfg_data_i[CHN_W-1:0]) > MAX_CHANNELS) begin
                chn_q <= CHN_W'(MAX_CHANNELS);
              end else begin
                chn_q <= cfg_data_i[CHN_W-1:0];
              end
            end
            wp_q <= '0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
              head_q[i]  <= '0;
              count_q[i] <= '0;
            end
          end
          if (start_i) begin
            len_q    <= frame_length_i;
            stamp_q  <= stamp_i;
            tags_q   <= {nal_kind_i, data_kind_i};
            reader_q <= reader_i;
            state_q  <= (opcode_i == OP_POP) ? S_POP_CHK : S_PLACE;
          end
        end
        S_PLACE: begin
          offset_q        <= '0;
          out_length_q    <= '0;
          out_stamp_q     <= '0;
          out_data_kind_q <= '0;
          out_nal_kind_q  <= '0;
          if (reject) begin
            status_q <= ST_REJECT;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end else begin
            if (place_sum > MW'(size_q)) begin
              start_q <= '0;
              wp_q    <= PW'(len_q);
              end_q   <= EW'(len_q);
            end else begin
              start_q <= wp_q;
              wp_q    <= (place_sum == MW'(size_q)) ? '0 : PW'(place_sum);
              end_q   <= EW'(place_sum);
            end
            ch_q    <= '0;
            state_q <= S_HEAD;
          end
        end
        S_HEAD: begin
          state_q <= (count_q[ch_q] == '0) ? S_APPEND : S_EVICT;
        end
        S_EVICT: begin
          if (overlap) begin
            head_q[ch_q]  <= head_inc(head_q[ch_q]);
            count_q[ch_q] <= count_q[ch_q] - 1'b1;
            state_q       <= S_HEAD;
          end else begin
            state_q <= S_APPEND;
          end
        end
        S_APPEND: begin
          if (cur_full) begin
            head_q[ch_q] <= head_inc(head_q[ch_q]);
          end else begin
            count_q[ch_q] <= count_q[ch_q] + 1'b1;
          end
          if (last_ch) begin
            status_q <= ST_OK;
            offset_q <= OFFSET_W'(start_q);
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end else begin
            ch_q    <= ch_q + 1'b1;
            state_q <= S_HEAD;
          end
        end
        S_POP_CHK: begin
          offset_q        <= '0;
          out_length_q    <= '0;
          out_stamp_q     <= '0;
          out_data_kind_q <= '0;
          out_nal_kind_q  <= '0;
          if (reader_q >= chn_q) begin
            status_q <= ST_BAD_CHANNEL;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end else if (count_q[cur_ch] == '0) begin
            status_q <= ST_EMPTY;
            done_q   <= 1'b1;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_POP_OUT;
          end
        end
        S_POP_OUT: begin
          status_q               <= ST_OK;
          offset_q               <= OFFSET_W'(rd_start);
          out_length_q           <= rd_len;
          out_stamp_q            <= rd_stamp;
          out_data_kind_q        <= rd_tags[KIND_W-1:0];
          out_nal_kind_q         <= rd_tags[TAG_W-1:KIND_W];
          head_q[reader_q[CHW-1:0]]  <= head_inc(head_q[reader_q[CHW-1:0]]);
          count_q[reader_q[CHW-1:0]] <= count_q[reader_q[CHW-1:0]] - 1'b1;
          done_q                 <= 1'b1;
          state_q                <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o          = (state_q != S_IDLE);
  assign cfg_ready_o     = (state_q == S_IDLE) && !start_i;
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign offset_o        = offset_q;
  assign out_length_o    = out_length_q;
  assign out_stamp_o     = out_stamp_q;
  assign out_data_kind_o = out_data_kind_q;
  assign out_nal_kind_o  = out_nal_kind_q;

  `MRRDP_ASSERT_MSG(a_done_pulse, done_o |=> !done_o, "done held longer than one cycle")
  `MRRDP_ASSERT_MSG(a_accept_busy, (start_i && !busy_o) |=> busy_o, "item taken but not busy")
  `MRRDP_ASSERT(a_fail_zero, (done_o && status_o != ST_OK) |-> (offset_o == '0 && out_length_o == '0))
  `MRRDP_ASSERT_MSG(a_evict_nonempty, (state_q == S_EVICT) |-> (count_q[ch_q] != '0), "evict from empty queue")
  `MRRDP_ASSERT(a_count_bound, count_q[ch_q] <= CW'(QUEUE_DEPTH))

endmodule
